### src/periodic_soft_timer_bank_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the periodic soft timer bank.
// Shared helpers that wrap concurrent assertions on the block clock.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_SOFT_TIMER_BANK_TOP_MACROS_SVH
`define PERIODIC_SOFT_TIMER_BANK_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSTB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pstb_pkg.sv
// ---------------------------------------------------------------------------
// pstb_pkg
// Types, constants and helpers shared by the periodic soft timer bank.
// ---------------------------------------------------------------------------
package pstb_pkg;

	localparam int NUM_TIMERS_DEF = 8;
	localparam int CNT_W          = 16;
	localparam int TPM_W          = 8;
	localparam int ID_W           = 8;
	localparam int FID_W          = 6;
	localparam int OP_W           = 3;
	localparam int ST_W           = 3;

	localparam logic [CNT_W-1:0] DEFAULT_LIMIT = 16'd1000;
	localparam logic [TPM_W-1:0] TPM_RESET     = 8'd1;

	// Opcodes of an input item.
	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_INIT    = 3'd1;
	localparam logic [OP_W-1:0] OP_CLAIM   = 3'd2;
	localparam logic [OP_W-1:0] OP_SETPER  = 3'd3;
	localparam logic [OP_W-1:0] OP_SETNTF  = 3'd4;
	localparam logic [OP_W-1:0] OP_UNCLAIM = 3'd5;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_UNINIT   = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_ID   = 3'd2;
	localparam logic [ST_W-1:0] ST_CONFLICT = 3'd3;
	localparam logic [ST_W-1:0] ST_UNUSED   = 3'd4;

	// Configuration register word indexes.
	localparam logic REG_TPM = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMD,
		S_CMD_DONE,
		S_TK_RD,
		S_TK_EVAL,
		S_TK_END
	} state_t;

	// Control from the sequencer to the count/limit store.
	typedef struct packed {
		logic rd;
		logic cnt_we;
		logic lim_we;
		logic clear;
	} mem_ctl_t;

	function automatic int idx_width(int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

### src/pstb_mem.sv
// ---------------------------------------------------------------------------
// pstb_mem
// Count and limit store: one write address, one registered read port,
// with per-entry valid bits that stand in for the reset values.
// ---------------------------------------------------------------------------
module pstb_mem #(
	parameter int NUM_TIMERS = pstb_pkg::NUM_TIMERS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  pstb_pkg::mem_ctl_t                            ctl,
	input  logic [pstb_pkg::idx_width(NUM_TIMERS)-1:0]    addr,
	input  logic [pstb_pkg::CNT_W-1:0]                    wr_cnt,
	input  logic [pstb_pkg::CNT_W-1:0]                    wr_lim,
	output logic [pstb_pkg::CNT_W-1:0]                    rd_cnt,
	output logic [pstb_pkg::CNT_W-1:0]                    rd_lim
);
	import pstb_pkg::*;

	logic [CNT_W-1:0]      cnt_mem [NUM_TIMERS];
	logic [CNT_W-1:0]      lim_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] cnt_vld_q;
	logic [NUM_TIMERS-1:0] lim_vld_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic [CNT_W-1:0]      rd_lim_q;
	logic                  rd_cnt_vld_q;
	logic                  rd_lim_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.cnt_we) begin
			cnt_mem[addr] <= wr_cnt;
		end
		if (ctl.lim_we) begin
			lim_mem[addr] <= wr_lim;
		end
		if (ctl.rd) begin
			rd_cnt_q <= cnt_mem[addr];
			rd_lim_q <= lim_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			lim_vld_q    <= '0;
			rd_cnt_vld_q <= 1'b0;
			rd_lim_vld_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				cnt_vld_q <= '0;
				lim_vld_q <= '0;
			end else begin
				if (ctl.cnt_we) begin
					cnt_vld_q[addr] <= 1'b1;
				end
				if (ctl.lim_we) begin
					lim_vld_q[addr] <= 1'b1;
				end
			end
			if (ctl.rd) begin
				rd_cnt_vld_q <= cnt_vld_q[addr];
				rd_lim_vld_q <= lim_vld_q[addr];
			end
		end
	end

	// An entry never written since reset or init reads as its reset value.
	assign rd_cnt = rd_cnt_vld_q ? rd_cnt_q : '0;
	assign rd_lim = rd_lim_vld_q ? rd_lim_q : DEFAULT_LIMIT;

endmodule

### src/pstb_core.sv
// ---------------------------------------------------------------------------
// pstb_core
// Sequencer of the timer bank: command checks, the tick walk over all
// timers with one increment/compare unit, and the result register.
// ---------------------------------------------------------------------------
`include "periodic_soft_timer_bank_top_macros.svh"

module pstb_core #(
	parameter int NUM_TIMERS = pstb_pkg::NUM_TIMERS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [pstb_pkg::TPM_W-1:0]                 tpm,
	// Input item.
	input  logic                                       in_vld,
	output logic                                       in_rdy,
	input  logic [pstb_pkg::OP_W-1:0]                  in_op,
	input  logic [pstb_pkg::ID_W-1:0]                  in_id,
	input  logic [pstb_pkg::CNT_W-1:0]                 in_period,
	input  logic                                       in_ntf,
	// Result item.
	output logic                                       out_vld,
	input  logic                                       out_rdy,
	output logic [pstb_pkg::ST_W-1:0]                  out_status,
	output logic                                       out_fired,
	output logic [pstb_pkg::FID_W-1:0]                 out_fid,
	output logic                                       out_last,
	// Count/limit store.
	output pstb_pkg::mem_ctl_t                         mem_ctl,
	output logic [pstb_pkg::idx_width(NUM_TIMERS)-1:0] mem_addr,
	output logic [pstb_pkg::CNT_W-1:0]                 mem_wr_cnt,
	output logic [pstb_pkg::CNT_W-1:0]                 mem_wr_lim,
	input  logic [pstb_pkg::CNT_W-1:0]                 mem_rd_cnt,
	input  logic [pstb_pkg::CNT_W-1:0]                 mem_rd_lim
);
	import pstb_pkg::*;

	localparam int IDX_W = idx_width(NUM_TIMERS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
	localparam logic [ID_W:0]    ID_LIMIT = (ID_W + 1)'(NUM_TIMERS);

	state_t                state_q, state_d;
	logic [OP_W-1:0]       op_q;
	logic [ID_W-1:0]       id_q;
	logic [CNT_W-1:0]      per_q;
	logic                  ntf_q;
	logic [ST_W-1:0]       status_q, status_d;
	logic [CNT_W-1:0]      prod_q;
	logic [IDX_W-1:0]      k_q;
	logic                  pend_vld_q;
	logic [FID_W-1:0]      pend_id_q;
	logic                  init_q;
	logic [NUM_TIMERS-1:0] claimed_q;
	logic [NUM_TIMERS-1:0] notify_q;
	logic                  out_vld_q;
	logic [ST_W-1:0]       out_status_q;
	logic                  out_fired_q;
	logic [FID_W-1:0]      out_fid_q;
	logic                  out_last_q;

	logic                  in_acc;
	logic                  out_free;
	logic                  load;
	logic [ST_W-1:0]       ld_status;
	logic                  ld_fired;
	logic [FID_W-1:0]      ld_fid;
	logic                  ld_last;
	logic                  k_adv;
	logic                  k_clr;
	logic                  apply_cmd;
	logic                  pend_set;
	logic                  pend_clr;
	logic [IDX_W-1:0]      id_idx;
	logic [CNT_W-1:0]      cnt_inc;
	logic                  fire;
	logic                  report;
	logic                  in_walk;

	assign in_rdy   = (state_q == S_IDLE);
	assign in_acc   = in_vld && in_rdy;
	assign out_free = !out_vld_q || out_rdy;
	assign id_idx   = id_q[IDX_W-1:0];
	assign in_walk  = (state_q == S_TK_RD || state_q == S_TK_EVAL || state_q == S_TK_END);

	// The shared unit: increment and limit compare of the timer under walk.
	assign cnt_inc = mem_rd_cnt + CNT_W'(1);
	assign fire    = (cnt_inc >= mem_rd_lim);
	assign report  = fire && notify_q[k_q];

	// Command checks, in priority order.
	always_comb begin
		status_d = ST_OK;
		if (op_q == OP_CLAIM || op_q == OP_SETPER || op_q == OP_SETNTF ||
			op_q == OP_UNCLAIM) begin
			if (!init_q) begin
				status_d = ST_UNINIT;
			end else if ({1'b0, id_q} >= ID_LIMIT) begin
				status_d = ST_BAD_ID;
			end else if (op_q == OP_CLAIM) begin
				status_d = claimed_q[id_idx] ? ST_CONFLICT : ST_OK;
			end else begin
				status_d = claimed_q[id_idx] ? ST_OK : ST_UNUSED;
			end
		end
	end

	// Next state and control.
	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		ld_status  = ST_OK;
		ld_fired   = 1'b0;
		ld_fid     = '0;
		ld_last    = 1'b1;
		k_adv      = 1'b0;
		k_clr      = 1'b0;
		apply_cmd  = 1'b0;
		pend_set   = 1'b0;
		pend_clr   = 1'b0;
		mem_ctl    = '0;
		mem_addr   = id_idx;
		mem_wr_cnt = '0;
		mem_wr_lim = prod_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					k_clr   = 1'b1;
					state_d = (in_op == OP_TICK) ? S_TK_RD : S_CMD;
				end
			end
			S_CMD: begin
				state_d = S_CMD_DONE;
			end
			S_CMD_DONE: begin
				if (out_free) begin
					load      = 1'b1;
					ld_status = status_q;
					apply_cmd = (status_q == ST_OK);
					if (status_q == ST_OK) begin
						case (op_q) inside
							OP_INIT: mem_ctl.clear = 1'b1;
							OP_CLAIM, OP_SETPER: mem_ctl.lim_we = 1'b1;
							OP_UNCLAIM: mem_ctl.cnt_we = 1'b1;
							default: ;
						endcase
					end
					state_d = S_IDLE;
				end
			end
			S_TK_RD: begin
				mem_addr = k_q;
				if (claimed_q[k_q]) begin
					mem_ctl.rd = 1'b1;
					state_d    = S_TK_EVAL;
				end else if (k_q == LAST_IDX) begin
					state_d = S_TK_END;
				end else begin
					k_adv = 1'b1;
				end
			end
			S_TK_EVAL: begin
				mem_addr   = k_q;
				mem_wr_cnt = fire ? '0 : cnt_inc;
				// A second report pushes the held one out with last clear.
				if (!(report && pend_vld_q && !out_free)) begin
					mem_ctl.cnt_we = 1'b1;
					if (report) begin
						pend_set = 1'b1;
						if (pend_vld_q) begin
							load     = 1'b1;
							ld_fired = 1'b1;
							ld_fid   = pend_id_q;
							ld_last  = 1'b0;
						end
					end
					if (k_q == LAST_IDX) begin
						state_d = S_TK_END;
					end else begin
						k_adv   = 1'b1;
						state_d = S_TK_RD;
					end
				end
			end
			S_TK_END: begin
				if (out_free) begin
					load     = 1'b1;
					ld_fired = pend_vld_q;
					ld_fid   = pend_vld_q ? pend_id_q : '0;
					pend_clr = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item fields and command scratch.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_op;
			id_q  <= in_id;
			per_q <= in_period;
			ntf_q <= in_ntf;
		end
		if (state_q == S_CMD) begin
			status_q <= status_d;
			prod_q   <= CNT_W'(per_q * tpm);
		end
		if (pend_set) begin
			pend_id_q <= FID_W'(k_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b0;
			claimed_q  <= '0;
			notify_q   <= '0;
			k_q        <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (k_clr) begin
				k_q <= '0;
			end else if (k_adv) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (pend_set) begin
				pend_vld_q <= 1'b1;
			end else if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end
			if (apply_cmd) begin
				case (op_q)
					OP_INIT: begin
						init_q    <= 1'b1;
						claimed_q <= '0;
						notify_q  <= '0;
					end
					OP_CLAIM: claimed_q[id_idx] <= 1'b1;
					OP_SETNTF: notify_q[id_idx] <= ntf_q;
					OP_UNCLAIM: begin
						claimed_q[id_idx] <= 1'b0;
						notify_q[id_idx]  <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_fired_q  <= ld_fired;
			out_fid_q    <= ld_fid;
			out_last_q   <= ld_last;
		end
	end

	assign out_vld    = out_vld_q;
	assign out_status = out_status_q;
	assign out_fired  = out_fired_q;
	assign out_fid    = out_fid_q;
	assign out_last   = out_last_q;

	`PSTB_ASSERT_SAME(a_no_overwrite, clk, arst_n, load, out_free, "result register overwritten")
	`PSTB_ASSERT_SAME(a_pend_in_tick, clk, arst_n, pend_vld_q, in_walk, "held report outside walk")
	`PSTB_ASSERT_SAME(a_k_range, clk, arst_n, 1'b1, ({1'b0, k_q} <= {1'b0, LAST_IDX}), "bad index")
	`PSTB_ASSERT_NEXT(a_busy_after_acc, clk, arst_n, in_acc, !in_rdy, "ready right after accept")

endmodule

### src/periodic_soft_timer_bank_top.sv
// ---------------------------------------------------------------------------
// periodic_soft_timer_bank_top
// Bank of periodic timers driven by a base tick, with command channel,
// result channel and one configuration register.
// ---------------------------------------------------------------------------
// The bank takes one item at a time on the slave stream and answers on the
// master stream. A command (init, claim, set period, set notify, unclaim or
// an unused opcode) goes from acceptance to its single status result in
// order: accept, then the checks and the period times ticks_per_ms
// product, then apply it and load the result register. A tick walks the
// timers in id order through one increment and compare unit fed by the
// single read port of the count/limit store: an unclaimed timer is
// skipped, a claimed one is read and then evaluated, and a closing step
// loads the final result. A tick gives one result per reporting timer in
// ascending id order, the last one flagged by tlast, or one empty result
// when nothing reports. Back-pressure on the master side stalls the walk
// only when a second report is ready while an earlier one is still held
// and the result register is full; a command result and the final result
// of a tick likewise wait until the result register is free.
// There is no clearing pass after reset; counts and limits read as 0 and
// 1000 until written.
// ---------------------------------------------------------------------------
module periodic_soft_timer_bank_top #(
	parameter int NUM_TIMERS = pstb_pkg::NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item: tdata = timer_id[7:0], period[23:8], notify_enable[24].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// tuser = opcode[2:0].
	input  logic [2:0]  s_tuser,
	// Result item: tdata = status[2:0], fired[3], fired_id[9:4].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pstb_pkg::*;

	localparam int IDX_W = idx_width(NUM_TIMERS);

	logic [TPM_W-1:0] tpm_q;
	logic             reg_sel;
	logic [ST_W-1:0]  res_status;
	logic             res_fired;
	logic [FID_W-1:0] res_fid;
	mem_ctl_t         mem_ctl;
	logic [IDX_W-1:0] mem_addr;
	logic [CNT_W-1:0] mem_wr_cnt;
	logic [CNT_W-1:0] mem_wr_lim;
	logic [CNT_W-1:0] mem_rd_cnt;
	logic [CNT_W-1:0] mem_rd_lim;

	// Word index of the register lies in paddr[2]; the byte offset is ignored.
	assign reg_sel = (paddr[2] == REG_TPM);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {24'd0, tpm_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= TPM_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tpm_q <= pwdata[TPM_W-1:0];
		end
	end

	pstb_core #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.tpm        (tpm_q),
		.in_vld     (s_tvalid),
		.in_rdy     (s_tready),
		.in_op      (s_tuser),
		.in_id      (s_tdata[7:0]),
		.in_period  (s_tdata[23:8]),
		.in_ntf     (s_tdata[24]),
		.out_vld    (m_tvalid),
		.out_rdy    (m_tready),
		.out_status (res_status),
		.out_fired  (res_fired),
		.out_fid    (res_fid),
		.out_last   (m_tlast),
		.mem_ctl    (mem_ctl),
		.mem_addr   (mem_addr),
		.mem_wr_cnt (mem_wr_cnt),
		.mem_wr_lim (mem_wr_lim),
		.mem_rd_cnt (mem_rd_cnt),
		.mem_rd_lim (mem_rd_lim)
	);

	pstb_mem #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.addr   (mem_addr),
		.wr_cnt (mem_wr_cnt),
		.wr_lim (mem_wr_lim),
		.rd_cnt (mem_rd_cnt),
		.rd_lim (mem_rd_lim)
	);

	assign m_tdata = {6'd0, res_fid, res_fired, res_status};

endmodule

### tb/timer_event_checker.sv
// ---------------------------------------------------------------------------
// Timer event checker
// Watches the command, result and configuration ports of the timer bank,
// keeps its own copy of the bank state and compares every result item.
// ---------------------------------------------------------------------------
module timer_event_checker #(
	parameter int         NUM_TIMERS = pstb_pkg::NUM_TIMERS_DEF,
	parameter logic [2:0] TPM_ADDR   = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pstb_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             fired;
		logic [FID_W-1:0] fired_id;
		logic             last;
	} report_t;

	report_t          due_reports[$];
	logic             bank_live;
	logic             claimed[NUM_TIMERS];
	logic             notify_on[NUM_TIMERS];
	logic [CNT_W-1:0] counts[NUM_TIMERS];
	logic [CNT_W-1:0] limits[NUM_TIMERS];
	logic [TPM_W-1:0] ticks_per_ms;
	int               errs;

	task automatic wipe_bank();
		for (int k = 0; k < NUM_TIMERS; k++) begin
			claimed[k]   = 1'b0;
			notify_on[k] = 1'b0;
			counts[k]    = '0;
			limits[k]    = DEFAULT_LIMIT;
		end
	endtask

	// Applies one command or tick to the bank copy and queues its results.
	task automatic advance_bank(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [15:0] period, input logic ntf);
		report_t          r;
		int               n;
		logic [ST_W-1:0]  st;
		int               t;
		n  = 0;
		st = ST_OK;
		t  = int'(id);
		if (op == OP_TICK) begin
			for (int k = 0; k < NUM_TIMERS; k++) begin
				if (claimed[k]) begin
					counts[k] = counts[k] + 16'd1;
					if (counts[k] >= limits[k]) begin
						counts[k] = '0;
						if (notify_on[k]) begin
							r = '{status: ST_OK, fired: 1'b1, fired_id: FID_W'(k), last: 1'b0};
							due_reports.push_back(r);
							n++;
						end
					end
				end
			end
			if (n == 0) begin
				r = '{status: ST_OK, fired: 1'b0, fired_id: '0, last: 1'b1};
				due_reports.push_back(r);
			end else begin
				due_reports[$].last = 1'b1;
			end
			return;
		end
		if (op == OP_INIT) begin
			wipe_bank();
			bank_live = 1'b1;
		end else if (op == OP_CLAIM || op == OP_SETPER || op == OP_SETNTF ||
				op == OP_UNCLAIM) begin
			if (!bank_live) begin
				st = ST_UNINIT;
			end else if (t >= NUM_TIMERS) begin
				st = ST_BAD_ID;
			end else if (op == OP_CLAIM) begin
				if (claimed[t]) begin
					st = ST_CONFLICT;
				end else begin
					claimed[t] = 1'b1;
					limits[t]  = period * ticks_per_ms;
				end
			end else if (!claimed[t]) begin
				st = ST_UNUSED;
			end else if (op == OP_SETPER) begin
				limits[t] = period * ticks_per_ms;
			end else if (op == OP_SETNTF) begin
				notify_on[t] = ntf;
			end else begin
				claimed[t]   = 1'b0;
				notify_on[t] = 1'b0;
				counts[t]    = '0;
			end
		end
		r = '{status: st, fired: 1'b0, fired_id: '0, last: 1'b1};
		due_reports.push_back(r);
	endtask

	task automatic check_report(input logic [15:0] data, input logic tl);
		report_t want;
		if (due_reports.size() == 0) begin
			$error("result item with nothing expected: tdata=%h tlast=%b", data, tl);
			errs++;
			return;
		end
		want = due_reports.pop_front();
		if (data[2:0] !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, data[2:0]);
			errs++;
		end
		if (data[3] !== want.fired) begin
			$error("fired: expected %0d, actual %0d", want.fired, data[3]);
			errs++;
		end
		if (data[9:4] !== want.fired_id) begin
			$error("fired_id: expected %0d, actual %0d", want.fired_id, data[9:4]);
			errs++;
		end
		if (tl !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, tl);
			errs++;
		end
	endtask

	// Results are checked before a new item is predicted, so a result and an
	// item accepted on the same edge keep their order in the queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_bank();
			bank_live    = 1'b0;
			ticks_per_ms = TPM_RESET;
			errs         = 0;
			due_reports.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_report(m_tdata, m_tlast);
			if (psel && penable && pwrite && pready && paddr[2] == TPM_ADDR[2])
				ticks_per_ms = pwdata[TPM_W-1:0];
			if (s_tvalid && s_tready)
				advance_bank(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[24]);
			pending    <= due_reports.size();
			fail_count <= errs;
		end
	end

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// Timer bank testbench
// Drives commands and ticks into the periodic timer bank under random
// back-pressure and several ticks_per_ms settings; a checker beside the
// block predicts and compares every result item.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pstb_pkg::*;

	localparam int         NT        = NUM_TIMERS_DEF;
	localparam logic [2:0] TPM_ADDR  = {REG_TPM, 2'b00};
	// Opcodes the block does not use; they must answer ok and change nothing.
	localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;
	localparam int         LONG_HOLD = 300;
	localparam int         RAND_ITEMS = 35;
	localparam int         CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// timer_id[7:0], period[23:8], notify_enable[24].
	logic [31:0] s_tdata = '0;
	// opcode[2:0].
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status[2:0], fired[3], fired_id[9:4].
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int   fail_count;
	int   pending;
	int   cycles = 0;
	logic tx_gaps = 1'b1;
	logic rx_gaps = 1'b1;
	logic hold_req = 1'b0;
	logic hold_taken;
	int   rx_wait;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	periodic_soft_timer_bank_top #(.NUM_TIMERS(NT)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	timer_event_checker #(.NUM_TIMERS(NT), .TPM_ADDR(TPM_ADDR)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	// Result sink. Normally it stalls in short random bursts; once, on request,
	// it holds off for a long stretch so the result register stays full, the
	// tick walk stops and the block stops taking items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			rx_wait    <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			rx_wait    <= LONG_HOLD;
			m_tready   <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait  <= rx_wait - 1;
			m_tready <= 1'b0;
		end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
			rx_wait  <= $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offers one item and returns at the edge that accepts it. The valid line
	// stays high on return, so back-to-back items see no bubble unless a
	// random gap is drawn.
	task automatic offer_item(input logic [OP_W-1:0] op, input logic [7:0] id,
			input logic [15:0] period, input logic ntf);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, ntf, period, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Waits until the bank has answered everything, lets a full tick walk go
	// by in case the sequencer is still winding down, then writes the rate.
	task automatic write_tpm(input logic [TPM_W-1:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * NT + 4) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= TPM_ADDR;
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// A well-formed start: init, then every timer claimed with a short
	// period and most of them reporting.
	task automatic bring_up_bank();
		offer_item(OP_INIT, 8'd0, 16'd0, 1'b0);
		for (int k = 0; k < NT; k++) begin
			offer_item(OP_CLAIM, 8'(k), 16'($urandom_range(0, 3)), 1'b0);
			offer_item(OP_SETNTF, 8'(k), 16'd0, $urandom_range(0, 3) != 0);
		end
	endtask

	// Mostly valid traffic on live timers: ticks dominate, with a steady churn
	// of claims and releases so conflicts and unused ids keep turning up.
	// Now and then an id past the bank, a full-range period, or a stray init.
	task automatic random_traffic(input int count);
		int                pick;
		logic [OP_W-1:0]   op;
		logic [7:0]        id;
		logic [15:0]       period;
		logic              ntf;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)      op = OP_TICK;
			else if (pick < 38) op = OP_INIT;
			else if (pick < 56) op = OP_CLAIM;
			else if (pick < 70) op = OP_SETPER;
			else if (pick < 84) op = OP_SETNTF;
			else if (pick < 96) op = OP_UNCLAIM;
			else if (pick < 98) op = OP_RSVD_A;
			else                op = OP_RSVD_B;
			if ($urandom_range(0, 99) < 85)
				id = 8'($urandom_range(0, NT - 1));
			else
				id = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 70)
				period = 16'($urandom_range(0, 4));
			else
				period = 16'($urandom_range(0, 65535));
			ntf = $urandom_range(0, 3) != 0;
			offer_item(op, id, period, ntf);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset rate of one tick per ms.
		// Before init: an empty tick, and a command refused as not initialized.
		offer_item(OP_TICK, 8'd0, 16'd0, 1'b0);
		offer_item(OP_CLAIM, 8'd0, 16'd1, 1'b0);
		// Unused opcodes answer ok even before init.
		offer_item(OP_RSVD_A, 8'd255, 16'hFFFF, 1'b1);
		offer_item(OP_RSVD_B, 8'd0, 16'd0, 1'b0);
		offer_item(OP_INIT, 8'd0, 16'd0, 1'b0);
		// Ids past the bank, first just past it and then the largest.
		offer_item(OP_CLAIM, 8'd8, 16'd5, 1'b0);
		offer_item(OP_SETNTF, 8'd255, 16'd0, 1'b1);
		// Command on a timer nobody claimed.
		offer_item(OP_SETPER, 8'd2, 16'd3, 1'b0);
		// A zero limit fires on every tick; a second claim is a conflict.
		offer_item(OP_CLAIM, 8'd0, 16'd0, 1'b0);
		offer_item(OP_CLAIM, 8'd0, 16'd4, 1'b0);
		offer_item(OP_SETNTF, 8'd0, 16'd0, 1'b1);
		// Largest period on the highest timer.
		offer_item(OP_CLAIM, 8'd7, 16'hFFFF, 1'b0);
		offer_item(OP_SETNTF, 8'd7, 16'hFFFF, 1'b1);
		offer_item(OP_CLAIM, 8'd3, 16'd5, 1'b0);
		offer_item(OP_SETNTF, 8'd3, 16'd0, 1'b1);
		offer_item(OP_TICK, 8'd0, 16'd0, 1'b0);
		offer_item(OP_TICK, 8'd0, 16'd0, 1'b0);
		offer_item(OP_TICK, 8'd0, 16'd0, 1'b0);
		// Limit of timer 3 dropped below its count: it fires on the next tick.
		offer_item(OP_SETPER, 8'd3, 16'd1, 1'b0);
		offer_item(OP_TICK, 8'd0, 16'd0, 1'b0);
		// Timer 0 keeps firing but silently once its notify is off.
		offer_item(OP_SETNTF, 8'd0, 16'd0, 1'b0);
		offer_item(OP_TICK, 8'd0, 16'd0, 1'b0);
		// Unclaim must release the named timer, not timer 0.
		offer_item(OP_UNCLAIM, 8'd3, 16'd0, 1'b0);
		offer_item(OP_UNCLAIM, 8'd3, 16'd0, 1'b0);
		offer_item(OP_INIT, 8'd0, 16'd0, 1'b0);

		// Zero rate: every limit is zero, so each tick reports every timer
		// with notify on. The long sink stall lands here, where the result
		// stream is densest.
		write_tpm(8'd0);
		hold_req <= 1'b1;
		bring_up_bank();
		random_traffic(RAND_ITEMS);

		// Largest rate: limits grow large and fires come only from zero
		// periods or wrapped products.
		write_tpm(8'd255);
		bring_up_bank();
		random_traffic(RAND_ITEMS);

		write_tpm(8'($urandom_range(2, 254)));
		bring_up_bank();
		random_traffic(RAND_ITEMS);

		// Final stretch back at the reset rate with both sides running flat out.
		write_tpm(8'd1);
		tx_gaps = 1'b0;
		rx_gaps <= 1'b0;
		bring_up_bank();
		random_traffic(RAND_ITEMS);

		// Drain: wait for every expected result, then a full tick walk more so
		// a stray extra result would still be caught.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4 * NT + 8) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
